// File: rtl/core/timestamp_to_epoch_seconds_assert.svh
// assertion macros shared by the timestamp converter
`ifndef TIMESTAMP_TO_EPOCH_SECONDS_ASSERT_SVH
`define TIMESTAMP_TO_EPOCH_SECONDS_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timestamp converter check failed");

// next-cycle implication, sampled on clk, off during reset
`define TSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timestamp converter check failed");

`endif

// File: rtl/core/tse_pkg.sv
package tse_pkg;

  localparam logic [4:0] TS_LEN  = 5'd19;
  localparam logic [4:0] POS_SAT = 5'd20;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FORMAT = 2'd1,
    STATUS_RANGE  = 2'd2
  } status_t;

  // one finished timestamp handed from the parser to the converter
  typedef struct packed {
    logic        fmt_bad;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } tse_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tse_qstat_t;

endpackage

// File: rtl/core/tse_front.sv
module tse_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] char_in
  input  logic              in_tuser,   // [0] first_char
  input  logic              in_tlast,   // last_char
  input  tse_pkg::tse_qstat_t q_stat,
  output logic              q_push,
  output tse_pkg::tse_rec_t q_rec
);
  import tse_pkg::*;

  function automatic logic [6:0] push7(logic [6:0] acc, logic [3:0] d);
    logic [9:0] t;
    t = {acc, 3'b000} + {2'b00, acc, 1'b0} + {6'd0, d};
    return t[6:0];
  endfunction

  function automatic logic [13:0] push14(logic [13:0] acc, logic [3:0] d);
    logic [16:0] t;
    t = {acc, 3'b000} + {2'b00, acc, 1'b0} + {13'd0, d};
    return t[13:0];
  endfunction

  logic [4:0]  pos_r, pos_nxt;
  logic        fmt_r, fmt_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  month_r, month_nxt, day_r, day_nxt, hour_r, hour_nxt;
  logic [6:0]  minute_r, minute_nxt, second_r, second_nxt;

  logic [4:0]  p, p_inc;
  logic        f;
  logic [13:0] y;
  logic [6:0]  mo, d, h, mi, s;
  logic        is_digit;
  logic [3:0]  dv;
  logic        accept;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign is_digit  = (in_tdata >= 8'h30) && (in_tdata <= 8'h39);
  assign dv        = in_tdata[3:0];

  always_comb begin
    // a first mark drops whatever partial timestamp was held
    p  = in_tuser ? 5'd0  : pos_r;
    f  = in_tuser ? 1'b0  : fmt_r;
    y  = in_tuser ? 14'd0 : year_r;
    mo = in_tuser ? 7'd0  : month_r;
    d  = in_tuser ? 7'd0  : day_r;
    h  = in_tuser ? 7'd0  : hour_r;
    mi = in_tuser ? 7'd0  : minute_r;
    s  = in_tuser ? 7'd0  : second_r;

    if (p >= TS_LEN) begin
      f = 1'b1;
    end else if (p == 5'd4 || p == 5'd7) begin
      if (in_tdata != 8'h2D) f = 1'b1;
    end else if (p == 5'd10) begin
      if (in_tdata != 8'h5F) f = 1'b1;
    end else if (p == 5'd13 || p == 5'd16) begin
      if (in_tdata != 8'h3A) f = 1'b1;
    end else if (!is_digit) begin
      f = 1'b1;
    end else if (p < 5'd4) begin
      y = push14(y, dv);
    end else if (p < 5'd7) begin
      mo = push7(mo, dv);
    end else if (p < 5'd10) begin
      d = push7(d, dv);
    end else if (p < 5'd13) begin
      h = push7(h, dv);
    end else if (p < 5'd16) begin
      mi = push7(mi, dv);
    end else begin
      s = push7(s, dv);
    end

    p_inc = (p < POS_SAT) ? p + 5'd1 : p;

    q_rec.fmt_bad = f || (p_inc != TS_LEN);
    q_rec.year    = y;
    q_rec.month   = mo;
    q_rec.day     = d;
    q_rec.hour    = h;
    q_rec.minute  = mi;
    q_rec.second  = s;
    q_push        = accept && in_tlast;

    pos_nxt    = pos_r;
    fmt_nxt    = fmt_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    if (accept) begin
      if (in_tlast) begin
        pos_nxt    = '0;
        fmt_nxt    = 1'b0;
        year_nxt   = '0;
        month_nxt  = '0;
        day_nxt    = '0;
        hour_nxt   = '0;
        minute_nxt = '0;
        second_nxt = '0;
      end else begin
        pos_nxt    = p_inc;
        fmt_nxt    = f;
        year_nxt   = y;
        month_nxt  = mo;
        day_nxt    = d;
        hour_nxt   = h;
        minute_nxt = mi;
        second_nxt = s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      fmt_r    <= 1'b0;
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      fmt_r    <= fmt_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// File: rtl/core/tse_queue.sv
module tse_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tse_pkg::tse_rec_t   push_rec,
  input  logic                pop,
  output tse_pkg::tse_rec_t   head_rec,
  output tse_pkg::tse_qstat_t stat
);
  import tse_pkg::*;

  tse_rec_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head_rec   = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/tse_back.sv
module tse_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tse_pkg::tse_qstat_t q_stat,
  input  tse_pkg::tse_rec_t   head_rec,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,  // [38:0] epoch_seconds
  output logic [1:0]          out_tuser   // [1:0] parse_status
);
  import tse_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_YOE,
    S_DOE,
    S_DAYS,
    S_SECS
  } state_t;

  localparam logic signed [17:0] DAY_SECS = 18'sd86400;

  // days from march 1 to the first of the month, march-based year
  function automatic logic [8:0] month_offset(logic [6:0] m);
    logic [8:0] r;
    case (m)
      7'd1:    r = 9'd306;
      7'd2:    r = 9'd337;
      7'd3:    r = 9'd0;
      7'd4:    r = 9'd31;
      7'd5:    r = 9'd61;
      7'd6:    r = 9'd92;
      7'd7:    r = 9'd122;
      7'd8:    r = 9'd153;
      7'd9:    r = 9'd184;
      7'd10:   r = 9'd214;
      7'd11:   r = 9'd245;
      7'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  state_t             state_r, state_nxt;
  status_t            status_r, status_nxt;
  logic [13:0]        yy_r, yy_nxt;
  logic [8:0]         doy_r, doy_nxt;
  logic [16:0]        tod_r, tod_nxt;
  logic [4:0]         q_r, q_nxt;
  logic [8:0]         yoe_r, yoe_nxt;
  logic [17:0]        doe_r, doe_nxt;
  logic [21:0]        eraday_r, eraday_nxt;
  logic signed [22:0] days_r, days_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [38:0]        out_data_r, out_data_nxt;
  status_t            out_status_r, out_status_nxt;

  logic               range_bad;
  logic [18:0]        tod_w;
  logic [26:0]        div_prod;
  logic [13:0]        yoe_w;
  logic [17:0]        m365;
  logic [14:0]        m41;
  logic signed [40:0] sec_prod;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};
  assign out_tuser  = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    status_nxt     = status_r;
    yy_nxt         = yy_r;
    doy_nxt        = doy_r;
    tod_nxt        = tod_r;
    q_nxt          = q_r;
    yoe_nxt        = yoe_r;
    doe_nxt        = doe_r;
    eraday_nxt     = eraday_r;
    days_nxt       = days_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    q_pop          = 1'b0;

    range_bad = (head_rec.month < 7'd1) || (head_rec.month > 7'd12) ||
                (head_rec.day < 7'd1) || (head_rec.day > 7'd31) ||
                (head_rec.hour > 7'd23) || (head_rec.minute > 7'd59) ||
                (head_rec.second > 7'd60);
    tod_w = 19'(head_rec.hour) * 19'd3600 + 19'(head_rec.minute) * 19'd60 +
            19'(head_rec.second);
    div_prod = 27'(yy_r) * 27'd5243;
    yoe_w    = yy_r - 14'(q_r) * 14'd400;
    m365     = 18'(yoe_r) * 18'd365;
    m41      = 15'(yoe_r) * 15'd41;
    sec_prod = days_r * DAY_SECS;

    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          if (head_rec.fmt_bad) status_nxt = STATUS_FORMAT;
          else if (range_bad)   status_nxt = STATUS_RANGE;
          else                  status_nxt = STATUS_OK;
          // year shifted up by one era so the division stays unsigned
          yy_nxt  = (head_rec.month <= 7'd2) ? head_rec.year + 14'd399
                                             : head_rec.year + 14'd400;
          doy_nxt = month_offset(head_rec.month) + {2'b00, head_rec.day} - 9'd1;
          tod_nxt = tod_w[16:0];
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // reciprocal of 400, exact over the shifted year range
        q_nxt     = div_prod[25:21];
        state_nxt = S_YOE;
      end
      S_YOE: begin
        yoe_nxt   = yoe_w[8:0];
        state_nxt = S_DOE;
      end
      S_DOE: begin
        // yoe / 100 through reciprocal of 100
        doe_nxt    = m365 + 18'(yoe_r[8:2]) - 18'(m41[13:12]) + 18'(doy_r);
        eraday_nxt = 22'(q_r) * 22'd146097;
        state_nxt  = S_DAYS;
      end
      S_DAYS: begin
        // undo the one-era shift and the march 1 year 0 offset together
        days_nxt  = $signed({1'b0, eraday_r}) + $signed({5'd0, doe_r}) -
                    23'sd865565;
        state_nxt = S_SECS;
      end
      S_SECS: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt   = (status_r == STATUS_OK) ?
                           sec_prod[38:0] + {22'd0, tod_r} : 39'd0;
          out_status_nxt = status_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r     <= status_nxt;
    yy_r         <= yy_nxt;
    doy_r        <= doy_nxt;
    tod_r        <= tod_nxt;
    q_r          <= q_nxt;
    yoe_r        <= yoe_nxt;
    doe_r        <= doe_nxt;
    eraday_r     <= eraday_nxt;
    days_r       <= days_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

// File: rtl/core/timestamp_to_epoch_seconds.sv
// timestamp_to_epoch_seconds
// input stream: one ascii character of a YYYY-MM-DD_HH:MM:SS timestamp per
// transaction; in_tuser marks the first character (drops any partial text),
// in_tlast marks the final one. a stream without first marks restarts after
// each last character.
// output stream: one transaction per last character; out_tdata carries the
// signed seconds since 1970-01-01 (zero on error), out_tuser the status:
// ok, format error (length, separator, digit) or range error.
// throughput: one character per cycle while in_tready is high. each finished
// timestamp steps through the date converter's states (idle, div, yoe, doe,
// days, secs), whose sequencer handles one at a time; a two-entry queue sits
// between parser and converter. out_tvalid rises when the secs state loads
// the result into the output register. in_tready drops only while the queue
// is full, which needs timestamps shorter than about six characters back to
// back, or a stalled receiver. when out_tready is low the result holds in the
// output register, the converter waits and the queue then the input fill up behind it.
// reset (rst_n low, synchronous) clears the parser, queue and output valid.
module timestamp_to_epoch_seconds (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tuser,   // [0] first_char
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [38:0] epoch_seconds, [39] zero
  output logic [1:0]  out_tuser   // [1:0] parse_status
);
  import tse_pkg::*;

  tse_qstat_t q_stat;
  tse_rec_t   push_rec;
  tse_rec_t   head_rec;
  logic       q_push;
  logic       q_pop;

  tse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_rec     (push_rec)
  );

  tse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .head_rec (head_rec),
    .stat     (q_stat)
  );

  tse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head_rec   (head_rec),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`include "timestamp_to_epoch_seconds_assert.svh"

  `TSE_ASSERT_NOW(a_no_push_full, q_stat.full, !q_push)
  `TSE_ASSERT_NOW(a_no_pop_empty, q_stat.empty, !q_pop)
  `TSE_ASSERT_NOW(a_err_zero, out_tvalid && (out_tuser != STATUS_OK), out_tdata == 40'd0)

endmodule
